>>> src/cps_pkg.sv
// ============================================================================
// CAN packet segmenter package
// Shared widths, register indexes and the configuration struct.
// ============================================================================
package cps_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int SLOT_SHIFT  = 5;

    localparam int CMD_W     = 5;
    localparam int SLOT_W    = 3;
    localparam int LEN_W     = 8;
    localparam int BYTE_W    = 8;
    localparam int NODE_W    = 8;
    localparam int IDX_W     = 5;
    localparam int FILL_W    = 4;
    localparam int EXT_ID_W  = 29;
    localparam int PAYLOAD_W = FRAME_BYTES * BYTE_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ID = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_ID   = 8'd1;

    typedef struct packed {
        logic [NODE_W-1:0] source_id;
        logic [NODE_W-1:0] dest_id;
    } t_node_cfg;

endpackage

>>> src/cps_cfg_regs.sv
// ============================================================================
// CAN packet segmenter configuration registers
// Holds the source and destination node identifiers written over the
// configuration port.
// ============================================================================
module cps_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cps_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output cps_pkg::t_node_cfg       o_cfg
);
    import cps_pkg::*;

    t_node_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Writes to an index outside the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_SOURCE_ID: r_cfg.source_id <= i_cfg_data;
                REG_DEST_ID:   r_cfg.dest_id   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> src/cps_frame_builder.sv
// ============================================================================
// CAN packet segmenter frame builder
// Input register, per-packet running state and the frame result register.
// ============================================================================
module cps_frame_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cps_pkg::t_node_cfg            i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cps_pkg::CMD_W-1:0]     i_cmd_type,
    input  logic [cps_pkg::SLOT_W-1:0]    i_slot,
    input  logic [cps_pkg::LEN_W-1:0]     i_packet_length,
    input  logic [cps_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cps_pkg::EXT_ID_W-1:0]  o_ext_id,
    output logic [cps_pkg::FILL_W-1:0]    o_dlc,
    output logic [cps_pkg::PAYLOAD_W-1:0] o_payload,
    output logic                          o_last_frame
);
    import cps_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_in_cmd;
    logic [SLOT_W-1:0] r_in_slot;
    logic [LEN_W-1:0]  r_in_len;
    logic [BYTE_W-1:0] r_in_byte;

    // Packet state
    logic [LEN_W-1:0]     r_bytes_taken;
    logic [FILL_W-1:0]    r_fill_count;
    logic [PAYLOAD_W-1:0] r_frame_bytes;
    logic [IDX_W-1:0]     r_frames_left;
    logic [CMD_W-1:0]     r_held_command;
    logic [SLOT_W-1:0]    r_held_slot;
    logic [LEN_W-1:0]     r_held_length;

    // Result register
    logic                 r_out_valid;
    logic [EXT_ID_W-1:0]  r_ext_id;
    logic [FILL_W-1:0]    r_dlc;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                 r_last_frame;

    logic                 out_free;
    logic                 process;
    logic                 first;
    logic [LEN_W-1:0]     len_fixed;
    logic [LEN_W-1:0]     len_minus1;
    logic [LEN_W-1:0]     cur_len;
    logic [CMD_W-1:0]     cur_cmd;
    logic [SLOT_W-1:0]    cur_slot;
    logic [IDX_W-1:0]     cur_frames_left;
    logic [FILL_W-1:0]    cur_fill;
    logic [PAYLOAD_W-1:0] cur_bytes;
    logic [PAYLOAD_W-1:0] n_frame_bytes;
    logic [FILL_W-1:0]    n_fill_count;
    logic [LEN_W-1:0]     n_bytes_taken;
    logic                 last;
    logic                 emit;
    logic [EXT_ID_W-1:0]  n_ext_id;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // A packet's header fields count only on its first byte.
    assign first      = (r_bytes_taken == '0);
    assign len_fixed  = (r_in_len == '0) ? LEN_W'(1) : r_in_len;
    assign len_minus1 = len_fixed - LEN_W'(1);

    always_comb begin
        cur_len         = first ? len_fixed : r_held_length;
        cur_cmd         = first ? r_in_cmd  : r_held_command;
        cur_slot        = first ? r_in_slot : r_held_slot;
        cur_frames_left = first ? len_minus1[LEN_W-1:3] : r_frames_left;
        cur_fill        = first ? '0 : r_fill_count;
        cur_bytes       = first ? '0 : r_frame_bytes;

        n_frame_bytes = cur_bytes;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (cur_fill[2:0] == 3'(k)) begin
                n_frame_bytes[k*BYTE_W +: BYTE_W] = r_in_byte;
            end
        end

        n_fill_count  = cur_fill + FILL_W'(1);
        n_bytes_taken = r_bytes_taken + LEN_W'(1);
        last          = (n_bytes_taken == cur_len);
        emit          = last || (n_fill_count >= FILL_W'(FRAME_BYTES));

        n_ext_id = {cur_cmd, i_cfg.source_id, i_cfg.dest_id, cur_slot, cur_frames_left};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_bytes_taken <= '0;
            r_fill_count  <= '0;
            r_frames_left <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (process) begin
                if (emit) begin
                    r_out_valid   <= 1'b1;
                    r_fill_count  <= '0;
                    r_frames_left <= last ? '0 : cur_frames_left - IDX_W'(1);
                    r_bytes_taken <= last ? '0 : n_bytes_taken;
                end else begin
                    r_fill_count  <= n_fill_count;
                    r_frames_left <= cur_frames_left;
                    r_bytes_taken <= n_bytes_taken;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd  <= i_cmd_type;
            r_in_slot <= i_slot;
            r_in_len  <= i_packet_length;
            r_in_byte <= i_data_byte;
        end
        if (process) begin
            r_held_command <= cur_cmd;
            r_held_slot    <= cur_slot;
            r_held_length  <= cur_len;
            r_frame_bytes  <= emit ? '0 : n_frame_bytes;
            if (emit) begin
                r_ext_id     <= n_ext_id;
                r_dlc        <= n_fill_count;
                r_payload    <= n_frame_bytes;
                r_last_frame <= last;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ext_id     = r_ext_id;
    assign o_dlc        = r_dlc;
    assign o_payload    = r_payload;
    assign o_last_frame = r_last_frame;

endmodule

>>> src/can_packet_segmenter.sv
// ============================================================================
// CAN packet segmenter
// Cuts a byte stream into CAN extended frames of up to eight bytes.
// ============================================================================
// The block takes one packet byte per transfer and sustains one byte per
// clock cycle while the output is not stalled. The byte that completes a
// frame is held first in the input register. The frame is then loaded
// into the result register as soon as the output side is free, and it is
// offered on the output straight from that register. The packet
// counters are updated by a short step between the two registers. The
// command, slot and length travel with every byte but count only on the
// first byte of a packet; a length of zero is treated as one. A frame is
// produced whenever eight bytes have gathered or the packet's final byte
// arrives. Its 29-bit identifier holds the command in bits 28:24, the source
// node in 23:16, the destination node in 15:8, the slot in 7:5 and a frame
// index in 4:0 that counts down to zero on the final frame. Bytes fill the
// payload from bits 7:0 upwards and unused bytes are zero. The node
// identifiers are sampled when a frame is formed, so a write takes effect
// from the next frame formed; it should be made only while no byte is held
// in the input register. While a frame waits on a stalled output, one more
// byte is still taken into the input register, and the input then stalls.
// ============================================================================
module can_packet_segmenter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cps_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [cps_pkg::CMD_W-1:0]     i_cmd_type,
    input  logic [cps_pkg::SLOT_W-1:0]    i_slot,
    input  logic [cps_pkg::LEN_W-1:0]     i_packet_length,
    input  logic [cps_pkg::BYTE_W-1:0]    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [cps_pkg::EXT_ID_W-1:0]  o_ext_id,
    output logic [cps_pkg::FILL_W-1:0]    o_dlc,
    output logic [cps_pkg::PAYLOAD_W-1:0] o_payload,
    output logic                          o_last_frame
);
    import cps_pkg::*;

    t_node_cfg node_cfg;

    // Register file for the node identifiers; it always accepts a write.
    cps_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (node_cfg)
    );

    // Datapath: input register, packet counters and frame result register.
    cps_frame_builder u_frame_builder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (node_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd_type      (i_cmd_type),
        .i_slot          (i_slot),
        .i_packet_length (i_packet_length),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ext_id        (o_ext_id),
        .o_dlc           (o_dlc),
        .o_payload       (o_payload),
        .o_last_frame    (o_last_frame)
    );

endmodule

>>> bench/can_packet_segmenter_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// CAN packet segmenter testbench
// Streams packets byte by byte through the segmenter and checks every frame
// against a cycle-free prediction of the cutting, numbering and identifier
// assembly, under random idling on both sides and changing node identifiers.
// ============================================================================
module can_packet_segmenter_tb;

    import cps_pkg::*;

    // ------------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------------
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int CALM_PHASE      = 3;     // no idling on either side here
    localparam int LONG_PHASE      = 5;     // the next packet started from here on has maximum length
    localparam int SETTLE_CYCLES   = 4;     // covers the two-stage pipeline plus margin
    localparam int TAIL_CYCLES     = 8;
    localparam int IDLE_PERCENT    = 36;
    localparam int STALL_LIMIT     = 2000;  // cycles without any transfer

    // Indexes that the block does not decode; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(REG_DEST_ID + 1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

    typedef struct packed {
        logic [EXT_ID_W-1:0]  ext_id;
        logic [FILL_W-1:0]    dlc;
        logic [PAYLOAD_W-1:0] payload;
        logic                 last_frame;
    } t_can_frame;

    typedef enum logic {ROW_BYTE, ROW_REG_WRITE} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CMD_W-1:0]     cmd;
        logic [SLOT_W-1:0]    slot;
        logic [LEN_W-1:0]     len;
        logic [BYTE_W-1:0]    data;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] reg_value;
        bit                   typed;
        t_can_frame           want;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic [CMD_W-1:0]     i_cmd_type      = '0;
    logic [SLOT_W-1:0]    i_slot          = '0;
    logic [LEN_W-1:0]     i_packet_length = '0;
    logic [BYTE_W-1:0]    i_data_byte     = '0;
    logic                 i_out_stall     = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [EXT_ID_W-1:0]  o_ext_id;
    logic [FILL_W-1:0]    o_dlc;
    logic [PAYLOAD_W-1:0] o_payload;
    logic                 o_last_frame;

    always #4 i_clk = ~i_clk;

    can_packet_segmenter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd_type      (i_cmd_type),
        .i_slot          (i_slot),
        .i_packet_length (i_packet_length),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ext_id        (o_ext_id),
        .o_dlc           (o_dlc),
        .o_payload       (o_payload),
        .o_last_frame    (o_last_frame)
    );

    // ------------------------------------------------------------------------
    // Predicted segmenter state. The node identifiers mirror the registers;
    // the rest follows the packet currently being cut.
    // ------------------------------------------------------------------------
    logic [NODE_W-1:0]    node_source = '0;
    logic [NODE_W-1:0]    node_dest   = '0;
    logic [LEN_W-1:0]     seg_taken   = '0;
    logic [FILL_W-1:0]    seg_fill    = '0;
    logic [PAYLOAD_W-1:0] seg_bytes   = '0;
    logic [IDX_W-1:0]     seg_index   = '0;
    logic [CMD_W-1:0]     seg_cmd     = '0;
    logic [SLOT_W-1:0]    seg_slot    = '0;
    logic [LEN_W-1:0]     seg_len     = '0;

    t_can_frame pending_frames[$];
    t_stim_row  stim_table[$];

    bit calm = 1'b0;
    int mismatches    = 0;
    int bytes_sent    = 0;
    int frames_seen   = 0;
    int packets_done  = 0;
    int reg_writes    = 0;
    int quiet_cycles  = 0;

    // Works out what one byte does to the segmenter. The header fields only
    // count on the first byte of a packet, and a length of zero stands for one.
    // A frame leaves once eight bytes have gathered or the packet is complete.
    task automatic segment_byte(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data,
                                output bit emitted, output t_can_frame frame);
        logic [LEN_W:0] eff_len;
        bit             last;
        emitted = 1'b0;
        frame   = '0;
        if (seg_taken == 0) begin
            eff_len   = (len == 0) ? (LEN_W+1)'(1) : {1'b0, len};
            seg_cmd   = cmd;
            seg_slot  = slot;
            seg_len   = eff_len[LEN_W-1:0];
            seg_index = IDX_W'((eff_len + FRAME_BYTES - 1) / FRAME_BYTES - 1);
            seg_fill  = '0;
            seg_bytes = '0;
        end
        seg_bytes[BYTE_W*seg_fill[2:0] +: BYTE_W] = data;
        seg_fill  = seg_fill + 1'b1;
        seg_taken = seg_taken + 1'b1;
        last = (seg_taken == seg_len);
        if (last || seg_fill >= FRAME_BYTES) begin
            emitted          = 1'b1;
            frame.ext_id     = {seg_cmd, node_source, node_dest, seg_slot, seg_index};
            frame.dlc        = seg_fill;
            frame.payload    = seg_bytes;
            frame.last_frame = last;
            seg_fill  = '0;
            seg_bytes = '0;
            seg_index = seg_index - 1'b1;
            if (last) begin
                seg_taken = '0;
                seg_index = '0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [PAYLOAD_W-1:0] got,
                                   input logic [PAYLOAD_W-1:0] wanted);
        $display("[%0t] frame %0d: %s got 0x%0h, expected 0x%0h",
                 $realtime, frames_seen, what, got, wanted);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus tasks. Everything is driven at the falling edge and every
    // handshake is judged at the rising edge, before the block updates.
    // ------------------------------------------------------------------------

    // Presents one byte, possibly after a random gap, holds it until the
    // transfer happens and then records whatever frame it should produce.
    // Where a directed row carries a hand-worked frame, that is expected
    // instead of the prediction.
    task automatic send_byte(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                             input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data,
                             input bit typed, input t_can_frame want);
        bit         emitted;
        t_can_frame frame;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cmd_type      <= cmd;
        i_slot          <= slot;
        i_packet_length <= len;
        i_data_byte     <= data;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        segment_byte(cmd, slot, len, data, emitted, frame);
        if (emitted)
            pending_frames.push_back(typed ? want : frame);
    endtask

    // Takes the input side idle, waits for every outstanding frame, then
    // gives bytes still inside the pipeline time to settle.
    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        if (index == REG_SOURCE_ID)
            node_source = value;
        else if (index == REG_DEST_ID)
            node_dest = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void row_byte(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                     input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data);
        t_stim_row row;
        row.kind      = ROW_BYTE;
        row.cmd       = cmd;
        row.slot      = slot;
        row.len       = len;
        row.data      = data;
        row.reg_index = '0;
        row.reg_value = '0;
        row.typed     = 1'b0;
        row.want      = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void row_frame(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                                      input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] data,
                                      input t_can_frame want);
        row_byte(cmd, slot, len, data);
        stim_table[$].typed = 1'b1;
        stim_table[$].want  = want;
    endfunction

    function automatic void row_reg(input logic [CFG_IDX_W-1:0] index,
                                    input logic [CFG_DAT_W-1:0] value);
        row_byte('0, '0, '0, '0);
        stim_table[$].kind      = ROW_REG_WRITE;
        stim_table[$].reg_index = index;
        stim_table[$].reg_value = value;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall, except during the calm phase.
    // ------------------------------------------------------------------------
    always @(negedge i_clk)
        i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

    // Each frame transfer is matched against the oldest outstanding frame.
    always @(posedge i_clk) begin : frame_check
        t_can_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                report_mismatch("unexpected frame, identifier", PAYLOAD_W'(o_ext_id), '0);
            end else begin
                want = pending_frames.pop_front();
                if (o_ext_id !== want.ext_id)
                    report_mismatch("identifier", PAYLOAD_W'(o_ext_id),
                                    PAYLOAD_W'(want.ext_id));
                if (o_dlc !== want.dlc)
                    report_mismatch("length code", PAYLOAD_W'(o_dlc), PAYLOAD_W'(want.dlc));
                if (o_payload !== want.payload)
                    report_mismatch("payload", o_payload, want.payload);
                if (o_last_frame !== want.last_frame)
                    report_mismatch("final-frame flag", PAYLOAD_W'(o_last_frame),
                                    PAYLOAD_W'(want.last_frame));
                if (want.last_frame)
                    packets_done++;
            end
        end
    end

    // Watchdog: the run is stuck if no transfer of any kind happens for a
    // long while. Gaps and stalls are short, so this limit is generous.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d frames outstanding",
                     $realtime, quiet_cycles, pending_frames.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        int                   gen_left;
        bit                   want_long;
        logic [CMD_W-1:0]     cmd;
        logic [SLOT_W-1:0]    slot;
        logic [LEN_W-1:0]     len;
        logic [CFG_DAT_W-1:0] src;
        logic [CFG_DAT_W-1:0] dst;

        // Directed rows. Hand-worked frames are given where they are obvious:
        // the state straight after reset, and the extreme header values with
        // node identifiers of all zeros and all ones.
        // A zero length is treated as a single-byte packet.
        row_frame(5'd0, 3'd0, 8'd0, 8'hA5, {29'h0, 4'd1, 64'hA5, 1'b1});
        row_frame(5'd31, 3'd7, 8'd1, 8'hFF, {29'h1F0000E0, 4'd1, 64'hFF, 1'b1});
        // Both node identifiers to all ones, then two writes to undecoded
        // indexes, which must change nothing.
        row_reg(REG_SOURCE_ID, 8'hFF);
        row_reg(REG_DEST_ID, 8'hFF);
        row_reg(REG_UNUSED_LOW, 8'h00);
        row_reg(REG_UNUSED_TOP, 8'h5A);
        row_frame(5'd31, 3'd7, 8'd1, 8'h00, {29'h1FFFFFE0, 4'd1, 64'h0, 1'b1});
        // Exactly one full frame. The header fields of the later bytes swing
        // between their extremes and must be ignored.
        row_byte(5'h15, 3'd2, 8'd8, 8'h01);
        for (int k = 2; k <= 8; k++)
            row_byte(k[0] ? 5'd31 : 5'd0, k[0] ? 3'd7 : 3'd0, k[0] ? 8'd0 : 8'd255, 8'(k));
        // Nine bytes: a full frame with index one, then a one-byte remainder.
        row_byte(5'h0A, 3'd5, 8'd9, 8'hF0);
        for (int k = 1; k <= 8; k++)
            row_byte(5'(k), 3'(k), 8'(k), 8'hF0 + 8'(k));
        // Node identifiers rewritten part-way through a packet: the frame
        // that follows must carry the new values.
        row_byte(5'd3, 3'd1, 8'd3, 8'h11);
        row_reg(REG_SOURCE_ID, 8'h3C);
        row_reg(REG_DEST_ID, 8'hC3);
        row_byte(5'd0, 3'd0, 8'd0, 8'h22);
        row_byte(5'd31, 3'd7, 8'd255, 8'h33);

        // Reset is held from time zero and released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_REG_WRITE) begin
                settle_block();
                write_register(stim_table[i].reg_index, stim_table[i].reg_value);
            end else begin
                send_byte(stim_table[i].cmd, stim_table[i].slot, stim_table[i].len,
                          stim_table[i].data, stim_table[i].typed, stim_table[i].want);
            end
        end

        // Random part. Packets are mostly short, now and then of moderate
        // length, occasionally of zero length, and one runs to the maximum
        // so that the frame index starts from its top value. Packets carry
        // on across phase boundaries, so some register writes land mid-packet.
        gen_left  = 0;
        want_long = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_block();
            case (ph)
                2: begin
                    src = '1;
                    dst = '0;
                end
                6: begin
                    src = '0;
                    dst = '1;
                end
                default: begin
                    src = CFG_DAT_W'($urandom_range(255));
                    dst = CFG_DAT_W'($urandom_range(255));
                end
            endcase
            write_register(REG_SOURCE_ID, src);
            write_register(REG_DEST_ID, dst);
            if (ph == 4)
                write_register(CFG_IDX_W'($urandom_range(255, REG_UNUSED_LOW)),
                               CFG_DAT_W'($urandom));
            calm = (ph == CALM_PHASE);
            if (ph == LONG_PHASE)
                want_long = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd  = CMD_W'($urandom_range(31));
                slot = SLOT_W'($urandom_range(7));
                len  = LEN_W'($urandom_range(255));
                if (gen_left == 0) begin
                    if (want_long) begin
                        len = 8'd255;
                        want_long = 1'b0;
                    end else begin
                        case ($urandom_range(9))
                            0:       len = 8'd0;
                            1, 2:    len = LEN_W'($urandom_range(120, 17));
                            default: len = LEN_W'($urandom_range(16, 1));
                        endcase
                    end
                    gen_left = (len == 0) ? 1 : int'(len);
                end
                gen_left--;
                send_byte(cmd, slot, len, 8'($urandom_range(255)), 1'b0, '0);
            end
        end
        calm = 1'b0;

        // Drain everything, then leave room for any stray frame to show.
        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes over %0d register writes; %0d frames closed %0d packets.",
                 bytes_sent, reg_writes, frames_seen, packets_done);
        $display("Random part ran %0d phases, one without idling; %0d mismatches logged.",
                 PHASES, mismatches);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> can_packet_segmenter.f
src/cps_pkg.sv
src/cps_cfg_regs.sv
src/cps_frame_builder.sv
src/can_packet_segmenter.sv
bench/can_packet_segmenter_tb.sv
